/* design/vaa_pkg.sv */
// Package for the vector axis/angle pipeline: payload types, result codes and CORDIC table.
// No dependencies.
package vaa_pkg;

  localparam int CompBits = 16;

  localparam logic [1:0] REL_SAME     = 2'd0;
  localparam logic [1:0] REL_OPPOSITE = 2'd1;
  localparam logic [1:0] REL_GENERAL  = 2'd2;

  localparam int CordicSteps = 21;

  typedef struct packed {
    logic signed [CompBits-1:0] first_x;
    logic signed [CompBits-1:0] first_y;
    logic signed [CompBits-1:0] first_z;
    logic signed [CompBits-1:0] second_x;
    logic signed [CompBits-1:0] second_y;
    logic signed [CompBits-1:0] second_z;
  } vaa_in_t;

  typedef struct packed {
    logic signed [15:0] angle_centideg;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic [1:0]         relation;
  } vaa_out_t;

  // atan(2^-i) in 1/256 centidegree
  function automatic logic [20:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0:  atan_lut = 21'd1152000;
      5'd1:  atan_lut = 21'd680065;
      5'd2:  atan_lut = 21'd359328;
      5'd3:  atan_lut = 21'd182400;
      5'd4:  atan_lut = 21'd91554;
      5'd5:  atan_lut = 21'd45822;
      5'd6:  atan_lut = 21'd22916;
      5'd7:  atan_lut = 21'd11459;
      5'd8:  atan_lut = 21'd5730;
      5'd9:  atan_lut = 21'd2865;
      5'd10: atan_lut = 21'd1432;
      5'd11: atan_lut = 21'd716;
      5'd12: atan_lut = 21'd358;
      5'd13: atan_lut = 21'd179;
      5'd14: atan_lut = 21'd90;
      5'd15: atan_lut = 21'd45;
      5'd16: atan_lut = 21'd22;
      5'd17: atan_lut = 21'd11;
      5'd18: atan_lut = 21'd6;
      5'd19: atan_lut = 21'd3;
      5'd20: atan_lut = 21'd1;
      default: atan_lut = 21'd0;
    endcase
  endfunction

endpackage

/* design/vector_axis_angle.sv */
// Top level of the vector axis/angle pipeline with APB tolerance register.
// Depends on vaa_pkg, vaa_norm and vaa_acos.
//
// Fully pipelined: one vector pair may start every cycle (busy is always low) and each
// result appears on out_* with out_valid. The pipeline holds the 15-step normalization
// search (two stages per step), the 29-bit square root and 21 CORDIC stages. The
// receiver cannot stall the output. Register parallel_tolerance is at address 0.
module vector_axis_angle (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  vaa_pkg::vaa_in_t   in_data,
  output logic               out_valid,
  output vaa_pkg::vaa_out_t  out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam int NormLat = 34;
  localparam int AcosLat = 53;
  localparam int Tot = NormLat + 2 + AcosLat + 1;

  logic [14:0] tol_r;
  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign prdata = (paddr == 2'd0) ? {17'd0, tol_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= 15'd1;
    else if (psel && penable && pwrite && paddr == 2'd0) tol_r <= pwdata[14:0];
  end

  logic [Tot-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[Tot-2:0], start};
  end

  logic signed [15:0] ua [3];
  logic signed [15:0] ub [3];
  vaa_norm u_na (.clk, .v_x(in_data.first_x), .v_y(in_data.first_y),
                 .v_z(in_data.first_z), .u_x(ua[0]), .u_y(ua[1]), .u_z(ua[2]));
  vaa_norm u_nb (.clk, .v_x(in_data.second_x), .v_y(in_data.second_y),
                 .v_z(in_data.second_z), .u_x(ub[0]), .u_y(ub[1]), .u_z(ub[2]));

  // products
  logic signed [31:0] pd_r [3];
  logic signed [31:0] pc_r [6];
  logic signed [15:0] ua1_r [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) pd_r[i] <= ua[i] * ub[i];
    pc_r[0] <= ua[1] * ub[2]; pc_r[1] <= ua[2] * ub[1];
    pc_r[2] <= ua[2] * ub[0]; pc_r[3] <= ua[0] * ub[2];
    pc_r[4] <= ua[0] * ub[1]; pc_r[5] <= ua[1] * ub[0];
    for (int i = 0; i < 3; i++) ua1_r[i] <= ua[i];
  end

  function automatic logic signed [15:0] to_q14(input logic signed [31:0] c);
    logic [31:0] m;
    m = c[31] ? 32'(-c) : 32'(c);
    m = (m + 32'd8192) >> 14;
    if (m > 32'd16384) m = 32'd16384;
    to_q14 = c[31] ? -16'(m) : 16'(m);
  endfunction

  logic signed [31:0] dot_r;
  logic signed [15:0] ax_r [3];
  logic signed [15:0] ua2_r [3];
  always_ff @(posedge clk) begin
    dot_r <= pd_r[0] + pd_r[1] + pd_r[2];
    ax_r[0] <= to_q14(pc_r[0] - pc_r[1]);
    ax_r[1] <= to_q14(pc_r[2] - pc_r[3]);
    ax_r[2] <= to_q14(pc_r[4] - pc_r[5]);
    for (int i = 0; i < 3; i++) ua2_r[i] <= ua1_r[i];
  end

  logic [14:0] ang;
  vaa_acos u_acos (.clk, .dot(dot_r), .angle(ang));

  // delay relation/axis alongside acos
  logic [1:0]         rel_d [AcosLat];
  logic signed [15:0] axd [AcosLat][3];
  logic signed [31:0] tq;
  logic [1:0] rel0;
  logic signed [15:0] ax0 [3];
  always_comb begin
    tq = 32'(16384 - int'(tol_r)) * 32'sd16384;
    if (dot_r > tq) rel0 = vaa_pkg::REL_SAME;
    else if (dot_r < -tq) rel0 = vaa_pkg::REL_OPPOSITE;
    else rel0 = vaa_pkg::REL_GENERAL;
    for (int i = 0; i < 3; i++) ax0[i] = (rel0 == vaa_pkg::REL_GENERAL) ? ax_r[i] : ua2_r[i];
  end
  always_ff @(posedge clk) begin
    rel_d[0] <= rel0;
    axd[0] <= ax0;
    for (int k = 1; k < AcosLat; k++) begin
      rel_d[k] <= rel_d[k-1];
      axd[k] <= axd[k-1];
    end
  end

  logic [1:0] rl;
  assign rl = rel_d[AcosLat-1];
  always_ff @(posedge clk) begin
    out_data.relation <= rl;
    out_data.axis_x <= axd[AcosLat-1][0];
    out_data.axis_y <= axd[AcosLat-1][1];
    out_data.axis_z <= axd[AcosLat-1][2];
    case (rl)
      vaa_pkg::REL_SAME:     out_data.angle_centideg <= 16'sd0;
      vaa_pkg::REL_OPPOSITE: out_data.angle_centideg <= 16'sd18000;
      default:               out_data.angle_centideg <= -$signed({1'b0, ang});
    endcase
  end
  assign out_valid = vld_r[Tot-1];

  a_rel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.relation <= vaa_pkg::REL_GENERAL) else $error("bad relation");
  a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.relation == vaa_pkg::REL_SAME |-> out_data.angle_centideg == 16'sd0)
    else $error("same direction with nonzero angle");
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(start) && $past(rst_n) |-> vld_r[0]) else $error("lost item");
endmodule

/* design/vaa_norm.sv */
// Pipelined normalization of one signed 3-D vector to Q1.14 components.
// Depends on vaa_pkg. Accepts one vector per cycle.
module vaa_norm (
  input  logic                             clk,
  input  logic signed [vaa_pkg::CompBits-1:0] v_x,
  input  logic signed [vaa_pkg::CompBits-1:0] v_y,
  input  logic signed [vaa_pkg::CompBits-1:0] v_z,
  output logic signed [15:0]               u_x,
  output logic signed [15:0]               u_y,
  output logic signed [15:0]               u_z
);
  localparam int NSteps = 15;  // binary search steps over 0..16384
  localparam int Lat = 2 * NSteps + 2;  // sign delay up to the output stage

  // stage 1: magnitudes, halving
  logic [16:0] m_r [3];
  logic [2:0]  neg_r [Lat+1];
  logic [16:0] mag [3];
  logic [16:0] mx;
  logic [1:0]  sh;

  always_comb begin
    mag[0] = v_x[15] ? 17'(-$signed({v_x[15], v_x})) : {1'b0, v_x};
    mag[1] = v_y[15] ? 17'(-$signed({v_y[15], v_y})) : {1'b0, v_y};
    mag[2] = v_z[15] ? 17'(-$signed({v_z[15], v_z})) : {1'b0, v_z};
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    sh = (mx > 17'd32768) ? 2'd1 : 2'd0;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) m_r[i] <= mag[i] >> sh;
    neg_r[0] <= {v_z[15], v_y[15], v_x[15]};
    for (int k = 1; k <= Lat; k++) neg_r[k] <= neg_r[k-1];
  end

  // stage 2: squares
  logic [31:0] sq_r [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) sq_r[i] <= 32'(m_r[i] * m_r[i]);
  end

  // stage 3: sum of squares
  logic [33:0] s_r [NSteps+1];
  logic [31:0] q_r [NSteps+1][3];
  logic [14:0] lo_r [NSteps+1][3];
  logic [14:0] hi_r [NSteps+1][3];
  always_ff @(posedge clk) begin
    s_r[0] <= 34'(sq_r[0]) + 34'(sq_r[1]) + 34'(sq_r[2]);
    for (int i = 0; i < 3; i++) begin
      q_r[0][i]  <= sq_r[i];
      lo_r[0][i] <= 15'd0;
      hi_r[0][i] <= 15'd16384;
    end
  end

  // binary search, two stages per step: (2mid-1)^2, then (2mid-1)^2 * s <= q * 2^30
  genvar g, c;
  generate
    for (g = 0; g < NSteps; g++) begin : g_step
      logic [33:0] sm_r;
      always_ff @(posedge clk) begin
        sm_r     <= s_r[g];
        s_r[g+1] <= sm_r;
      end
      for (c = 0; c < 3; c++) begin : g_comp
        logic [15:0] mid;
        logic [15:0] mid_r;
        logic [29:0] tt_r;
        logic [14:0] lo_m_r;
        logic [14:0] hi_m_r;
        logic [31:0] q_m_r;
        logic [63:0] prod;
        logic        ok;
        assign mid = (16'(lo_r[g][c]) + 16'(hi_r[g][c]) + 16'd1) >> 1;
        always_ff @(posedge clk) begin
          mid_r  <= mid;
          tt_r   <= 30'((2 * 32'(mid) - 32'd1) * (2 * 32'(mid) - 32'd1));
          lo_m_r <= lo_r[g][c];
          hi_m_r <= hi_r[g][c];
          q_m_r  <= q_r[g][c];
        end
        always_comb begin
          prod = 64'(tt_r) * 64'(sm_r);
          ok   = (lo_m_r < hi_m_r) && (sm_r != 34'd0) && (prod <= {q_m_r, 30'd0});
        end
        always_ff @(posedge clk) begin
          if (ok) begin
            lo_r[g+1][c] <= 15'(mid_r);
            hi_r[g+1][c] <= hi_m_r;
          end else if (lo_m_r < hi_m_r) begin
            lo_r[g+1][c] <= lo_m_r;
            hi_r[g+1][c] <= 15'(mid_r - 16'd1);
          end else begin
            lo_r[g+1][c] <= lo_m_r;
            hi_r[g+1][c] <= hi_m_r;
          end
          q_r[g+1][c] <= q_m_r;
        end
      end
    end
  endgenerate

  logic [2:0] ng;
  assign ng = neg_r[Lat];
  always_ff @(posedge clk) begin
    u_x <= ng[0] ? -$signed({1'b0, lo_r[NSteps][0]}) : $signed({1'b0, lo_r[NSteps][0]});
    u_y <= ng[1] ? -$signed({1'b0, lo_r[NSteps][1]}) : $signed({1'b0, lo_r[NSteps][1]});
    u_z <= ng[2] ? -$signed({1'b0, lo_r[NSteps][2]}) : $signed({1'b0, lo_r[NSteps][2]});
  end
endmodule

/* design/vaa_acos.sv */
// Pipelined acos: Q2.28 cosine to centidegrees via sqrt and 21-step CORDIC vectoring.
// Depends on vaa_pkg. Input register, square-root stages, CORDIC setup, CORDIC stages, output register.
module vaa_acos (
  input  logic               clk,
  input  logic signed [31:0] dot,
  output logic [14:0]        angle
);
  localparam int SqSteps = 29;  // result bits of isqrt(2^56 - d^2) up to 2^28
  localparam int Cs = vaa_pkg::CordicSteps;

  logic signed [29:0] d_r [SqSteps+1];
  logic [57:0] rem_r [SqSteps+1];
  logic [28:0] root_r [SqSteps+1];
  logic signed [31:0] dc;
  logic [57:0] dd;

  // square of clamped value: 29x29 multiply
  always_comb begin
    dc = dot;
    if (dot > 32'sd268435456) dc = 32'sd268435456;
    if (dot < -32'sd268435456) dc = -32'sd268435456;
    dd = 58'(29'(dc[31] ? -dc : dc)) * 58'(29'(dc[31] ? -dc : dc));
  end

  always_ff @(posedge clk) begin
    d_r[0]    <= 30'(dc);
    rem_r[0]  <= (58'd1 << 56) - dd;
    root_r[0] <= '0;
  end

  // restoring square root, one result bit per stage, MSB first
  genvar g;
  generate
    for (g = 0; g < SqSteps; g++) begin : g_sq
      localparam int B = SqSteps - 1 - g;
      logic [58:0] tsq;
      logic [28:0] cand;
      assign cand = root_r[g] | (29'd1 << B);
      // rem holds v - root^2; test (root+2^B)^2 - root^2 = 2^(B+1)*root + 2^(2B)
      assign tsq = (59'(root_r[g]) << (B + 1)) + (59'd1 << (2 * B));
      always_ff @(posedge clk) begin
        if (59'(rem_r[g]) >= tsq) begin
          rem_r[g+1]  <= rem_r[g] - 58'(tsq);
          root_r[g+1] <= cand;
        end else begin
          rem_r[g+1]  <= rem_r[g];
          root_r[g+1] <= root_r[g];
        end
        d_r[g+1] <= d_r[g];
      end
    end
  endgenerate

  // CORDIC
  logic signed [31:0] x_r [Cs+1];
  logic signed [31:0] y_r [Cs+1];
  logic signed [23:0] z_r [Cs+1];
  always_ff @(posedge clk) begin
    if (d_r[SqSteps][29]) begin
      x_r[0] <= 32'(signed'({1'b0, root_r[SqSteps]}));
      y_r[0] <= -32'(d_r[SqSteps]);
      z_r[0] <= 24'sd2304000;
    end else begin
      x_r[0] <= 32'(d_r[SqSteps]);
      y_r[0] <= 32'(signed'({1'b0, root_r[SqSteps]}));
      z_r[0] <= 24'sd0;
    end
  end

  generate
    for (g = 0; g < Cs; g++) begin : g_cor
      logic signed [31:0] xs, ys;
      logic signed [23:0] at;
      assign xs = x_r[g] >>> g;
      assign ys = y_r[g] >>> g;
      assign at = 24'(vaa_pkg::atan_lut(5'(g)));
      always_ff @(posedge clk) begin
        if (y_r[g] > 0) begin
          x_r[g+1] <= x_r[g] + ys;
          y_r[g+1] <= y_r[g] - xs;
          z_r[g+1] <= z_r[g] + at;
        end else begin
          x_r[g+1] <= x_r[g] - ys;
          y_r[g+1] <= y_r[g] + xs;
          z_r[g+1] <= z_r[g] - at;
        end
      end
    end
  endgenerate

  logic signed [23:0] zc;
  logic [23:0] zr;
  always_comb begin
    zc = z_r[Cs];
    if (zc < 0) zc = '0;
    if (zc > 24'sd4608000) zc = 24'sd4608000;
    zr = 24'(zc) + 24'd128;
  end
  always_ff @(posedge clk) angle <= 15'(zr >> 8);
endmodule

/* tb/vector_axis_angle_checker.sv */
// Scoreboard for vector_axis_angle: predicts the angle, axis and relation of each vector pair.
// Depends on vaa_pkg; watches the start and out_valid transfers of the block.
`timescale 1ns / 100ps

module vector_axis_angle_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  vaa_pkg::vaa_in_t  in_data,
  input  logic              out_valid,
  input  vaa_pkg::vaa_out_t out_data,
  input  logic [14:0]       tolerance,
  output int                errors,
  output int                pending
);
  vaa_pkg::vaa_out_t expected_q[$];

  localparam longint AtanTab[21] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916,
    11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1};

  function automatic longint sqrt_floor(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void unit_vec(input longint v[3], output longint u[3]);
    longint unsigned m[3], mx, s, lo, hi, mid, t, rhs;
    mx = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    while (mx > 32768) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    for (int i = 0; i < 3; i++) s += m[i] * m[i];
    for (int i = 0; i < 3; i++) begin
      lo = 0;
      hi = 16384;
      rhs = (m[i] * m[i]) << 30;
      if (s != 0) begin
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          t = 2 * mid - 1;
          if (t * t * s <= rhs) lo = mid;
          else hi = mid - 1;
        end
      end
      u[i] = v[i] < 0 ? -longint'(lo) : longint'(lo);
    end
  endfunction

  function automatic longint round_axis(longint c);
    longint mag;
    mag = c < 0 ? -c : c;
    mag = (mag + 8192) >>> 14;
    if (mag > 16384) mag = 16384;
    return c < 0 ? -mag : mag;
  endfunction

  function automatic longint acos_centideg(longint dot);
    longint x, y, z, t, xs, ys;
    z = 0;
    if (dot > (64'sd1 <<< 28)) dot = 64'sd1 <<< 28;
    if (dot < -(64'sd1 <<< 28)) dot = -(64'sd1 <<< 28);
    x = dot;
    y = sqrt_floor((64'd1 << 56) - longint'(dot * dot));
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 9000 * 256;
    end
    for (int i = 0; i < 21; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z += AtanTab[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z -= AtanTab[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 18000 * 256) z = 18000 * 256;
    return (z + 128) >>> 8;
  endfunction

  function automatic vaa_pkg::vaa_out_t predict_rotation(vaa_pkg::vaa_in_t d, longint tol);
    longint a[3], b[3], ua[3], ub[3], dot;
    vaa_pkg::vaa_out_t r;
    a = '{d.first_x, d.first_y, d.first_z};
    b = '{d.second_x, d.second_y, d.second_z};
    unit_vec(a, ua);
    unit_vec(b, ub);
    dot = ua[0] * ub[0] + ua[1] * ub[1] + ua[2] * ub[2];
    if (dot > (16384 - tol) * 16384 || dot < (tol - 16384) * 16384) begin
      r.relation = dot > (16384 - tol) * 16384 ? vaa_pkg::REL_SAME : vaa_pkg::REL_OPPOSITE;
      r.angle_centideg = r.relation == vaa_pkg::REL_SAME ? 16'sd0 : 16'sd18000;
      r.axis_x = ua[0];
      r.axis_y = ua[1];
      r.axis_z = ua[2];
    end else begin
      r.relation = vaa_pkg::REL_GENERAL;
      r.angle_centideg = -acos_centideg(dot);
      r.axis_x = round_axis(ua[1] * ub[2] - ua[2] * ub[1]);
      r.axis_y = round_axis(ua[2] * ub[0] - ua[0] * ub[2]);
      r.axis_z = round_axis(ua[0] * ub[1] - ua[1] * ub[0]);
    end
    return r;
  endfunction

  function automatic int compare_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    vaa_pkg::vaa_out_t e;
    int bad;
    bad = 0;
    if (rst_n && start && !busy) expected_q.push_back(predict_rotation(in_data, tolerance));
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        bad++;
      end else begin
        e = expected_q.pop_front();
        bad += compare_field("angle_centideg", e.angle_centideg, out_data.angle_centideg);
        bad += compare_field("axis_x", e.axis_x, out_data.axis_x);
        bad += compare_field("axis_y", e.axis_y, out_data.axis_y);
        bad += compare_field("axis_z", e.axis_z, out_data.axis_z);
        bad += compare_field("relation", e.relation, out_data.relation);
      end
    end
    errors <= errors + bad;
    pending <= expected_q.size();
  end
endmodule

/* tb/vector_axis_angle_test.sv */
// Top of the vector_axis_angle testbench: clock, reset, APB tolerance writes and vector stimulus.
// Depends on vaa_pkg, vector_axis_angle and vector_axis_angle_checker.
`timescale 1ns / 100ps

module vector_axis_angle_test;
  logic clk, rst_n, start, busy, out_valid, psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  vaa_pkg::vaa_in_t in_data;
  vaa_pkg::vaa_out_t out_data;
  logic [14:0] tolerance;
  int errors, pending, sent;
  longint cycles;

  localparam logic [1:0] AddrTolerance = 2'd0;
  localparam longint CycleLimit = 400000;

  vector_axis_angle uut (.clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready);

  vector_axis_angle_checker chk (.clk, .rst_n, .start, .busy, .in_data, .out_valid,
    .out_data, .tolerance, .errors, .pending);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("vector_axis_angle_test NOT OK");
        $finish;
      end
    end
  end

  task automatic write_tolerance(logic [14:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= AddrTolerance; pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    tolerance = v;
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(0, 8)) - 4);
      3: return 16'(int'($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(vaa_pkg::vaa_in_t d);
    int gap;
    gap = $urandom_range(0, 99) < 70 ? 0 :
          ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 3));
    repeat (gap) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_data <= d;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic random_pair();
    vaa_pkg::vaa_in_t d;
    int k;
    d = {rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    k = $urandom_range(0, 9);
    if (k < 2) begin
      d.second_x = d.first_x; d.second_y = d.first_y; d.second_z = d.first_z;
      if (k == 1) begin
        d.second_x = -d.first_x; d.second_y = -d.first_y; d.second_z = -d.first_z;
      end
      d.second_x += 16'(int'($urandom_range(0, 6)) - 3);
    end else if (k == 2) begin
      d.second_x = 16'(d.first_x / 2); d.second_y = 16'(d.first_y / 2);
      d.second_z = 16'(d.first_z / 2);
    end
    send(d);
  endtask

  initial begin
    logic [14:0] tols[5] = '{15'd0, 15'd16384, 15'd200, 15'd32767, 15'd3000};
    vaa_pkg::vaa_in_t directed[$];
    rst_n = 0; start = 0; in_data = '0; psel = 0; penable = 0; pwrite = 0;
    paddr = '0; pwdata = '0; tolerance = 15'd1; sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    directed = '{
      {16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      {16'sd0, 16'sd0, 16'sd0, 16'sd5, 16'sd0, 16'sd0},
      {16'sd100, 16'sd0, 16'sd0, 16'sd300, 16'sd0, 16'sd0},
      {16'sd100, 16'sd0, 16'sd0, -16'sd3, 16'sd0, 16'sd0},
      {16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0},
      {16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff},
      {16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
      {16'sh7fff, 16'sh8000, 16'sd0, 16'sd0, 16'sh7fff, 16'sh8000},
      {16'sh8000, 16'sd0, 16'sd0, 16'sh7fff, 16'sd1, 16'sd0},
      {16'sd3, 16'sd4, 16'sd0, -16'sd4, 16'sd3, 16'sd1},
      {16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd2},
      {-16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd1},
      {16'sh7fff, 16'sd1, 16'sd0, 16'sh7fff, -16'sd1, 16'sd0},
      {16'sd0, 16'sd0, 16'sh7fff, 16'sd0, 16'sd0, 16'sh8000}};
    foreach (directed[i]) send(directed[i]);
    for (int p = 0; p < 6; p++) begin
      start <= 0;
      drain();
      write_tolerance(p == 0 ? 15'd1 : tols[p - 1]);
      if (p < 5) foreach (directed[i]) if (i < 4) send(directed[i]);
      repeat (270) random_pair();
    end
    start <= 0;
    drain();
    $display("Sent %0d vector pairs over six tolerance settings (0, 1, 200, 3000, 16384, 32767)",
             sent);
    $display("including zero, full-scale, parallel, antiparallel and orthogonal pairs");
    if (errors == 0) begin
      $display("vector_axis_angle_test OK");
    end else begin
      $display("vector_axis_angle_test NOT OK");
    end
    $finish;
  end
endmodule

/* sim.f */
design/vaa_pkg.sv
design/vaa_norm.sv
design/vaa_acos.sv
design/vector_axis_angle.sv
tb/vector_axis_angle_checker.sv
tb/vector_axis_angle_test.sv
